/* rtl/addressable_led_frame_driver_unit_assert.svh */
// assertion macros for the led frame driver
// used by the top level only; no other dependencies
`ifndef ADDRESSABLE_LED_FRAME_DRIVER_UNIT_ASSERT_SVH
`define ADDRESSABLE_LED_FRAME_DRIVER_UNIT_ASSERT_SVH
`ifndef SYNTH
// condition holds at every edge out of reset
`define ALFD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("led frame driver check failed");
// antecedent implies consequent on the next edge
`define ALFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("led frame driver check failed");
`else
`define ALFD_ASSERT_ALWAYS(label, clk, rst, expr)
`define ALFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/alfd_pkg.sv */
// shared types, constants and helpers for the led frame driver
// no dependencies
package alfd_pkg;

   localparam int LED_DEPTH_DEF = 1024;
   localparam int LED_COUNT_W   = 11;
   localparam int TICKS_W       = 15;
   localparam int PIXEL_W       = 24;
   localparam int CSR_INDEX_W   = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [4:0] BITS_PER_LED = 5'd24;

   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST  = 11'd1;
   localparam logic [TICKS_W-1:0]     ZERO_HIGH_RST  = 15'd14;
   localparam logic [TICKS_W-1:0]     ZERO_LOW_RST   = 15'd34;
   localparam logic [TICKS_W-1:0]     ONE_HIGH_RST   = 15'd34;
   localparam logic [TICKS_W-1:0]     ONE_LOW_RST    = 15'd14;

   typedef enum logic [1:0] {
      OP_WRITE_PIXEL = 2'd0,
      OP_CLEAR_ALL   = 2'd1,
      OP_REFRESH     = 2'd2,
      OP_TICK        = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LED_COUNT = 3'd0,
      REG_ZERO_HIGH = 3'd1,
      REG_ZERO_LOW  = 3'd2,
      REG_ONE_HIGH  = 3'd3,
      REG_ONE_LOW   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ENG_CLEAR,
      ENG_RUN,
      ENG_LOAD
   } eng_state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [9:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      op_type             kind;
      logic [9:0]         led_index;
      logic [PIXEL_W-1:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic [LED_COUNT_W-1:0] led_count;
      logic [TICKS_W-1:0]     zero_high_ticks;
      logic [TICKS_W-1:0]     zero_low_ticks;
      logic [TICKS_W-1:0]     one_high_ticks;
      logic [TICKS_W-1:0]     one_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic sending;
      logic clearing;
   } eng_status_type;

   // a zero duration behaves as one tick
   function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
      at_least_one = (v == '0) ? TICKS_W'(1) : v;
   endfunction

endpackage

/* rtl/addressable_led_frame_driver_unit.sv */
// channel   ports                                   direction
// request   req_push, req_full, req_payload          in  (command transactions)
// response  rsp_empty, rsp_pop, rsp_payload          out (one result per command)
// config    csr_wr_en, csr_index, csr_wdata          in  (register writes)
//
// pixel write, tick and ignored commands complete in the run state; a refresh
// and a tick that moves on to the next led also pass through the load state,
// which waits for the registered read of the pixel store. a clear sweeps the
// store, one entry a cycle. after reset the same sweep runs over all LED_DEPTH
// entries before commands are executed. front and result queues are two deep;
// a full result queue stalls the engine, which then backs up the front queue.
//
// top level of the led frame driver; depends on alfd_pkg, alfd_front,
// alfd_engine, alfd_rsp_queue and the assertion macro header
`include "addressable_led_frame_driver_unit_assert.svh"
module addressable_led_frame_driver_unit
   import alfd_pkg::*;
#(
   parameter int LED_DEPTH = LED_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_payload,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICKS_W-1:0]     csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           cmd_valid;
   cmd_type        cmd;
   logic           cmd_pop;
   logic           rsp_full;
   logic           eng_push;
   rsp_type        eng_rsp;
   eng_status_type eng_status;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_LED_COUNT: cfg_in.led_count       = csr_wdata[LED_COUNT_W-1:0];
            REG_ZERO_HIGH: cfg_in.zero_high_ticks = csr_wdata;
            REG_ZERO_LOW:  cfg_in.zero_low_ticks  = csr_wdata;
            REG_ONE_HIGH:  cfg_in.one_high_ticks  = csr_wdata;
            REG_ONE_LOW:   cfg_in.one_low_ticks   = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count       <= LED_COUNT_RST;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_RST;
         cfg_ff.zero_low_ticks  <= ZERO_LOW_RST;
         cfg_ff.one_high_ticks  <= ONE_HIGH_RST;
         cfg_ff.one_low_ticks   <= ONE_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // command intake
   alfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // execution
   alfd_engine #(
      .LED_DEPTH (LED_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (eng_push),
      .rsp       (eng_rsp),
      .status    (eng_status)
   );

   // result queue
   alfd_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (eng_push),
      .push_data   (eng_rsp),
      .full        (rsp_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   // design checks
   `ALFD_ASSERT_ALWAYS(a_done_while_busy, clock, reset, !(eng_push && eng_rsp.frame_done) || eng_rsp.busy_res)
   `ALFD_ASSERT_ALWAYS(a_idle_line_low, clock, reset, !(eng_push && !eng_rsp.busy_res) || !eng_rsp.line_level)
   `ALFD_ASSERT_ALWAYS(a_no_send_in_clear, clock, reset, !(eng_status.clearing && eng_status.sending))
   `ALFD_ASSERT_NEXT(a_done_ends_frame, clock, reset, eng_push && eng_rsp.frame_done, !eng_status.sending)

endmodule

/* rtl/alfd_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module alfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/alfd_front.sv */
// front end: accepts request transactions, decodes them into commands
// and holds them in a short queue; depends on alfd_pkg
module alfd_front
   import alfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_payload,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type                cmd_q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   cmd_type                decoded;
   logic                   do_push;
   logic                   do_pop;

   // classify the opcode and pack the color as green, red, blue
   always_comb begin
      decoded.led_index = req_payload.led_index;
      decoded.pixel     = {req_payload.green, req_payload.red, req_payload.blue};
      case (req_payload.opcode)
         OP_WRITE_PIXEL: decoded.kind = OP_WRITE_PIXEL;
         OP_CLEAR_ALL:   decoded.kind = OP_CLEAR_ALL;
         OP_REFRESH:     decoded.kind = OP_REFRESH;
         OP_TICK:        decoded.kind = OP_TICK;
         default:        decoded.kind = OP_TICK;
      endcase
   end

   // queue pointers
   assign req_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

/* rtl/alfd_rsp_queue.sv */
// result queue between the engine and the response port
// depends on alfd_pkg
module alfd_rsp_queue
   import alfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_payload
);

   rsp_type                rsp_q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full        = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rsp_empty   = (count_ff == '0);
   assign do_push     = push && !full;
   assign do_pop      = rsp_pop && !rsp_empty;
   assign rsp_payload = rsp_q_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         rsp_q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/alfd_engine.sv */
// back end: pixel store, clear sweep and pulse train sequencer
// depends on alfd_pkg and alfd_ram
module alfd_engine
   import alfd_pkg::*;
#(
   parameter int LED_DEPTH = LED_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           cmd_valid,
   input  cmd_type        cmd,
   output logic           cmd_pop,
   input  logic           rsp_full,
   output logic           rsp_push,
   output rsp_type        rsp,
   output eng_status_type status
);

   localparam int AW   = (LED_DEPTH > 1) ? $clog2(LED_DEPTH) : 1;
   localparam int PW   = $clog2(LED_DEPTH + 1);
   localparam int CNTW = (PW > LED_COUNT_W) ? PW : LED_COUNT_W;
   localparam logic [AW-1:0]   LAST_ADDR = AW'(LED_DEPTH - 1);
   localparam logic [CNTW-1:0] MAX_CNT   = CNTW'(LED_DEPTH);

   eng_state_type       state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                sending_ff, sending_in;
   logic                low_ff, low_in;
   logic [TICKS_W-1:0]  ptl_ff, ptl_in;
   logic [PIXEL_W-1:0]  shift_ff, shift_in;
   logic [4:0]          left_ff, left_in;
   logic [CNTW-1:0]     ptr_ff, ptr_in;

   logic [CNTW-1:0]     cnt_ext;
   logic [CNTW-1:0]     act_count;
   logic [CNTW-1:0]     idx_ext;
   logic [CNTW-1:0]     ptr_inc;
   logic [TICKS_W-1:0]  ptl_dec;
   logic [4:0]          left_dec;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [PIXEL_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [PIXEL_W-1:0]  ram_rd_data;

   alfd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (LED_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // effective count and counter helpers
   assign cnt_ext   = CNTW'(cfg.led_count);
   assign act_count = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
   assign idx_ext   = CNTW'(cmd.led_index);
   assign ptr_inc   = ptr_ff + CNTW'(1);
   assign ptl_dec   = (ptl_ff == '0) ? '0 : ptl_ff - TICKS_W'(1);
   assign left_dec  = (left_ff == '0) ? '0 : left_ff - 5'd1;

   assign status.sending  = sending_ff;
   assign status.clearing = (state_ff == ENG_CLEAR);

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      sending_in  = sending_ff;
      low_in      = low_ff;
      ptl_in      = ptl_ff;
      shift_in    = shift_ff;
      left_in     = left_ff;
      ptr_in      = ptr_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp         = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_inc[AW-1:0];
      case (state_ff)
         // zero one entry per cycle
         ENG_CLEAR: begin
            ram_wr_en = 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ENG_RUN;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         // led word arrives from the store, start its first high phase
         ENG_LOAD: begin
            shift_in = ram_rd_data;
            left_in  = BITS_PER_LED;
            low_in   = 1'b0;
            ptl_in   = at_least_one(ram_rd_data[PIXEL_W-1] ? cfg.one_high_ticks
                                                           : cfg.zero_high_ticks);
            state_in = ENG_RUN;
         end
         ENG_RUN: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop        = 1'b1;
               rsp_push       = 1'b1;
               rsp.line_level = sending_ff & ~low_ff;
               rsp.busy_res   = sending_ff;
               case (cmd.kind)
                  OP_TICK: begin
                     if (sending_ff) begin
                        ptl_in = ptl_dec;
                        if (ptl_dec == '0) begin
                           if (!low_ff) begin
                              low_in = 1'b1;
                              ptl_in = at_least_one(shift_ff[PIXEL_W-1] ?
                                                    cfg.one_low_ticks :
                                                    cfg.zero_low_ticks);
                           end else begin
                              shift_in = {shift_ff[PIXEL_W-2:0], 1'b0};
                              left_in  = left_dec;
                              if (left_dec == '0) begin
                                 ptr_in = ptr_inc;
                                 if (ptr_inc >= act_count) begin
                                    sending_in     = 1'b0;
                                    low_in         = 1'b0;
                                    ptl_in         = '0;
                                    rsp.frame_done = 1'b1;
                                 end else begin
                                    ram_rd_en = 1'b1;
                                    state_in  = ENG_LOAD;
                                 end
                              end else begin
                                 low_in = 1'b0;
                                 ptl_in = at_least_one(shift_ff[PIXEL_W-2] ?
                                                       cfg.one_high_ticks :
                                                       cfg.zero_high_ticks);
                              end
                           end
                        end
                     end
                  end
                  OP_WRITE_PIXEL: begin
                     if (!sending_ff && (idx_ext < act_count)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = idx_ext[AW-1:0];
                        ram_wr_data = cmd.pixel;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     if (!sending_ff) begin
                        clr_addr_in = '0;
                        state_in    = ENG_CLEAR;
                     end
                  end
                  OP_REFRESH: begin
                     if (!sending_ff && (act_count != '0)) begin
                        ptr_in         = '0;
                        sending_in     = 1'b1;
                        low_in         = 1'b0;
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = '0;
                        state_in       = ENG_LOAD;
                        rsp.busy_res   = 1'b1;
                        rsp.line_level = 1'b1;
                     end
                  end
                  default: begin
                     rsp = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ENG_RUN;
         end
      endcase
   end

   // control registers; sweep the store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_CLEAR;
         clr_addr_ff <= '0;
         sending_ff  <= 1'b0;
         low_ff      <= 1'b0;
         ptl_ff      <= '0;
         left_ff     <= '0;
         ptr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         sending_ff  <= sending_in;
         low_ff      <= low_in;
         ptl_ff      <= ptl_in;
         left_ff     <= left_in;
         ptr_ff      <= ptr_in;
      end
   end

   // bit shifter
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

endmodule

/* verif/tb.sv */
// self-checking testbench for the addressable led frame driver unit
// depends on alfd_pkg and addressable_led_frame_driver_unit; predicts results
// from its model of the pixel store and bit timing, or takes a directed row's want
`timescale 1ns / 100ps
module tb;
   import alfd_pkg::*;

   localparam int RAND_CMDS = 1750;
   localparam int DIR_ROWS  = 34;
   localparam rsp_type IDLE_RSP  = 3'b000;
   localparam rsp_type BUSY_HIGH = 3'b110;

   // one row of the directed plan: a register write or a command transaction
   typedef struct packed {
      logic          is_csr;
      reg_index_type reg_sel;
      logic [14:0]   reg_val;
      req_type       item;
      logic          typed;
      rsp_type       want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   req_type                req_payload = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICKS_W-1:0]     csr_wdata = '0;

   // predicted driver state and register copies
   logic [23:0] pix_mem [0:1023];
   logic [23:0] shifter;
   logic [4:0]  bits_left;
   logic [10:0] led_ptr;
   logic        low_phase;
   logic [14:0] ticks_left;
   logic        frame_busy;
   logic [10:0] strip_len;
   logic [14:0] zero_hi_q, zero_lo_q, one_hi_q, one_lo_q;

   rsp_type      pending_rsp [$];
   rsp_type      head_rsp;
   plan_row_type dir_plan [DIR_ROWS];

   int accepted_cmds, results_seen, frames_seen, mismatch_count;
   int settings_run, holds_done, hold_left, burst_left;
   logic [31:0] rx_cycle;

   always #5 clock = ~clock;

   addressable_led_frame_driver_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // ---------------- prediction ----------------

   function automatic void wipe_pixels();
      for (int i = 0; i < 1024; i++) pix_mem[i] = '0;
   endfunction

   // count in use, capped at the store size
   function automatic logic [10:0] live_count();
      return (strip_len > 11'(LED_DEPTH_DEF)) ? 11'(LED_DEPTH_DEF) : strip_len;
   endfunction

   // phase length for the bit now at the top of the shifter, zero acts as one
   function automatic logic [14:0] phase_len(input logic low);
      logic [14:0] d;
      if (shifter[23]) d = low ? one_lo_q : one_hi_q;
      else d = low ? zero_lo_q : zero_hi_q;
      return (d == '0) ? 15'd1 : d;
   endfunction

   function automatic void load_led(input logic [10:0] n);
      shifter = (n < 11'(LED_DEPTH_DEF)) ? pix_mem[n[9:0]] : '0;
      bits_left = BITS_PER_LED;
      low_phase = 1'b0;
      ticks_left = phase_len(1'b0);
   endfunction

   // advances the predicted driver by one command and returns its result
   function automatic rsp_type pulse_step(input req_type cmd);
      rsp_type r;
      r = '0;
      if (cmd.opcode == OP_TICK) begin
         r.busy_res = frame_busy;
         r.line_level = frame_busy & ~low_phase;
         if (frame_busy) begin
            if (ticks_left != '0) ticks_left--;
            if (ticks_left == '0) begin
               if (!low_phase) begin
                  low_phase = 1'b1;
                  ticks_left = phase_len(1'b1);
               end else begin
                  shifter = shifter << 1;
                  if (bits_left != '0) bits_left--;
                  if (bits_left != '0) begin
                     low_phase = 1'b0;
                     ticks_left = phase_len(1'b0);
                  end else begin
                     // led finished, the count in force now decides the end
                     led_ptr++;
                     if (led_ptr >= live_count()) begin
                        frame_busy = 1'b0;
                        low_phase = 1'b0;
                        ticks_left = '0;
                        r.frame_done = 1'b1;
                     end else begin
                        load_led(led_ptr);
                     end
                  end
               end
            end
         end
      end else begin
         // commands other than a tick are dropped while a frame goes out
         if (!frame_busy) begin
            case (cmd.opcode)
               OP_WRITE_PIXEL: begin
                  if (11'(cmd.led_index) < live_count())
                     pix_mem[cmd.led_index] = {cmd.green, cmd.red, cmd.blue};
               end
               OP_CLEAR_ALL: wipe_pixels();
               default: begin
                  if (live_count() != '0) begin
                     led_ptr = '0;
                     frame_busy = 1'b1;
                     load_led('0);
                  end
               end
            endcase
         end
         r.busy_res = frame_busy;
         r.line_level = frame_busy & ~low_phase;
      end
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic req_type any_cmd();
      req_type c;
      c.opcode = 2'($urandom_range(0, 3));
      c.led_index = 10'($urandom_range(0, 1023));
      c.red = 8'($urandom_range(0, 255));
      c.green = 8'($urandom_range(0, 255));
      c.blue = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic req_type bare_cmd(input op_type op);
      req_type c;
      c = any_cmd();
      c.opcode = op;
      return c;
   endfunction

   function automatic plan_row_type cfg_row(input reg_index_type sel, input int val);
      plan_row_type p;
      p = '0;
      p.is_csr = 1'b1;
      p.reg_sel = sel;
      p.reg_val = 15'(val);
      return p;
   endfunction

   function automatic plan_row_type cmd_row(input op_type op, input int idx, input int red,
                                            input int green, input int blue);
      plan_row_type p;
      p = '0;
      p.item.opcode = op;
      p.item.led_index = 10'(idx);
      p.item.red = 8'(red);
      p.item.green = 8'(green);
      p.item.blue = 8'(blue);
      return p;
   endfunction

   function automatic plan_row_type chk_row(input op_type op, input int idx, input int red,
                                            input int green, input int blue,
                                            input rsp_type want);
      plan_row_type p;
      p = cmd_row(op, idx, red, green, blue);
      p.typed = 1'b1;
      p.want = want;
      return p;
   endfunction

   // offers one transaction in bursts with random gaps, predicts it once taken
   task automatic send(input req_type cmd, input logic typed, input rsp_type want);
      int gap;
      rsp_type got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= cmd;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (cmd.opcode == OP_TICK || !frame_busy) accepted_cmds++;
      got = pulse_step(cmd);
      pending_rsp.push_back(typed ? want : got);
   endtask

   // stop offering and wait until every result is back
   task automatic settle();
      req_push <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic reg_write(input reg_index_type sel, input logic [14:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      case (sel)
         REG_LED_COUNT: strip_len = val[10:0];
         REG_ZERO_HIGH: zero_hi_q = val;
         REG_ZERO_LOW:  zero_lo_q = val;
         REG_ONE_HIGH:  one_hi_q = val;
         REG_ONE_LOW:   one_lo_q = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // new random register set, extremes of the count included
   task automatic new_setting();
      logic [14:0] v;
      settle();
      case ($urandom_range(0, 9))
         0: v = 15'd0;
         1: v = 15'd2047;
         2: v = 15'd1024;
         3: v = 15'($urandom_range(4, 2047));
         default: v = 15'($urandom_range(1, 3));
      endcase
      reg_write(REG_LED_COUNT, v);
      for (int r = REG_ZERO_HIGH; r <= REG_ONE_LOW; r++) begin
         v = ($urandom_range(0, 5) == 0) ? 15'd0 : 15'($urandom_range(1, 4));
         reg_write(reg_index_type'(r), v);
      end
      settings_run++;
   endtask

   // a few pixel writes, a refresh at times, then mostly ticks to the frame end
   task automatic frame_burst(input int stop_at);
      int n;
      logic [10:0] span;
      req_type c;
      if (!frame_busy) begin
         span = live_count();
         n = $urandom_range(0, 4);
         repeat (n) begin
            c = bare_cmd(OP_WRITE_PIXEL);
            if ($urandom_range(0, 7) != 0 && span < 11'd1024)
               c.led_index = 10'($urandom_range(0, span));
            send(c, 1'b0, '0);
         end
         if ($urandom_range(0, 15) == 0) send(bare_cmd(OP_CLEAR_ALL), 1'b0, '0);
         // long strips only now and then, they are cut short by the next setting
         if (span <= 11'd8 || $urandom_range(0, 7) == 0)
            send(bare_cmd(OP_REFRESH), 1'b0, '0);
      end
      while (frame_busy && accepted_cmds < stop_at)
         send(($urandom_range(0, 19) == 0) ? any_cmd() : bare_cmd(OP_TICK), 1'b0, '0);
      repeat ($urandom_range(0, 2)) send(bare_cmd(OP_TICK), 1'b0, '0);
   endtask

   function automatic void flag_error(input string what);
      if (mismatch_count < 10) $display("mismatch: %s", what);
      mismatch_count++;
   endfunction

   // ---------------- receiver and checker ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               flag_error($sformatf("result with nothing pending: level %b busy %b done %b",
                                    rsp_payload.line_level, rsp_payload.busy_res,
                                    rsp_payload.frame_done));
            end else begin
               head_rsp = pending_rsp.pop_front();
               if (rsp_payload.line_level !== head_rsp.line_level ||
                   rsp_payload.busy_res !== head_rsp.busy_res ||
                   rsp_payload.frame_done !== head_rsp.frame_done)
                  flag_error($sformatf(
                     "result %0d: want level %b busy %b done %b, got level %b busy %b done %b",
                     results_seen, head_rsp.line_level, head_rsp.busy_res, head_rsp.frame_done,
                     rsp_payload.line_level, rsp_payload.busy_res, rsp_payload.frame_done));
               if (head_rsp.frame_done) frames_seen++;
            end
            results_seen++;
         end
         // long hold-offs fill both queues and back up the input
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (holds_done < 2 && results_seen >= 400 * (holds_done + 1)) begin
            hold_left = 300;
            holds_done++;
            rsp_pop <= 1'b0;
         end else begin
            case (rx_cycle[8:7])
               2'd0: rsp_pop <= 1'b1;
               2'd1: rsp_pop <= ($urandom_range(0, 1) == 0);
               2'd2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= (rx_cycle[1:0] != 2'd0);
            endcase
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      int stop_at;
      int stop_total;
      wipe_pixels();
      shifter = '0;
      bits_left = '0;
      led_ptr = '0;
      low_phase = 1'b0;
      ticks_left = '0;
      frame_busy = 1'b0;
      strip_len = LED_COUNT_RST;
      zero_hi_q = ZERO_HIGH_RST;
      zero_lo_q = ZERO_LOW_RST;
      one_hi_q = ONE_HIGH_RST;
      one_lo_q = ONE_LOW_RST;
      rx_cycle = '0;

      dir_plan = '{
         // idle behavior at reset settings, out of range indexes dropped
         chk_row(OP_TICK, 0, 0, 0, 0, IDLE_RSP),
         chk_row(OP_WRITE_PIXEL, 0, 8'h00, 8'hff, 8'h80, IDLE_RSP),
         chk_row(OP_WRITE_PIXEL, 1, 8'hff, 8'hff, 8'hff, IDLE_RSP),
         chk_row(OP_WRITE_PIXEL, 1023, 8'hff, 8'hff, 8'hff, IDLE_RSP),
         chk_row(OP_CLEAR_ALL, 0, 0, 0, 0, IDLE_RSP),
         // zero count: writes dropped, refresh sends nothing
         cfg_row(REG_LED_COUNT, 0),
         cfg_row(REG_ZERO_HIGH, 32767),
         cfg_row(REG_ZERO_LOW, 32767),
         cfg_row(REG_ONE_HIGH, 32767),
         cfg_row(REG_ONE_LOW, 32767),
         chk_row(OP_WRITE_PIXEL, 0, 8'hff, 8'hff, 8'hff, IDLE_RSP),
         chk_row(OP_REFRESH, 0, 0, 0, 0, IDLE_RSP),
         chk_row(OP_TICK, 0, 0, 0, 0, IDLE_RSP),
         // count above the store size is capped
         cfg_row(REG_LED_COUNT, 2047),
         chk_row(OP_WRITE_PIXEL, 1023, 8'hff, 8'hff, 8'hff, IDLE_RSP),
         chk_row(OP_WRITE_PIXEL, 0, 8'h0f, 8'hf0, 8'h01, IDLE_RSP),
         // short frame with zero durations acting as one tick
         cfg_row(REG_LED_COUNT, 2),
         cfg_row(REG_ZERO_HIGH, 0),
         cfg_row(REG_ZERO_LOW, 1),
         cfg_row(REG_ONE_HIGH, 2),
         cfg_row(REG_ONE_LOW, 0),
         chk_row(OP_WRITE_PIXEL, 1, 8'ha5, 8'h5a, 8'hc3, IDLE_RSP),
         chk_row(OP_REFRESH, 0, 0, 0, 0, BUSY_HIGH),
         // commands while busy are dropped
         chk_row(OP_WRITE_PIXEL, 0, 8'h12, 8'h34, 8'h56, BUSY_HIGH),
         chk_row(OP_CLEAR_ALL, 0, 0, 0, 0, BUSY_HIGH),
         chk_row(OP_REFRESH, 0, 0, 0, 0, BUSY_HIGH),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_TICK, 0, 0, 0, 0),
         cmd_row(OP_WRITE_PIXEL, 2, 8'h77, 8'h88, 8'h99)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (dir_plan[i]) begin
         if (dir_plan[i].is_csr) begin
            settle();
            reg_write(dir_plan[i].reg_sel, dir_plan[i].reg_val);
         end else begin
            send(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].want);
         end
      end

      // random settings, each with a run of frames and some noise
      stop_total = accepted_cmds + RAND_CMDS;
      while (accepted_cmds < stop_total) begin
         new_setting();
         stop_at = accepted_cmds + $urandom_range(100, 250);
         while (accepted_cmds < stop_at) begin
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 3)) send(any_cmd(), 1'b0, '0);
            else
               frame_burst(stop_at);
         end
      end

      settle();
      // room for a trailing clear sweep
      repeat (LED_DEPTH_DEF + 76) @(posedge clock);
      $display("covered %0d commands over %0d register settings, %0d results checked",
               accepted_cmds, settings_run + 4, results_seen);
      $display("%0d frames sent to the end, %0d receiver hold-offs, %0d mismatches",
               frames_seen, holds_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS addressable_led_frame_driver_unit");
      end else begin
         $display("FAIL addressable_led_frame_driver_unit");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("timeout with %0d results pending", pending_rsp.size());
      $display("FAIL addressable_led_frame_driver_unit");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/alfd_pkg.sv
rtl/alfd_ram.sv
rtl/alfd_front.sv
rtl/alfd_rsp_queue.sv
rtl/alfd_engine.sv
rtl/addressable_led_frame_driver_unit.sv
verif/tb.sv
